// File: sv/nir_pkg.sv
// Shared types, constants and helpers for the NEC IR stepper remote core.
package nir_pkg;

  localparam int unsigned US_W   = 15;
  localparam int unsigned MS_W   = 32;
  localparam int unsigned CODE_W = 32;
  localparam int unsigned DLY_W  = 16;
  localparam int unsigned IDX_W  = 4;

  localparam logic [US_W-1:0]   LEAD_SPACE_MIN_US = 15'd4000;
  localparam logic [US_W-1:0]   LEAD_SPACE_MAX_US = 15'd5000;
  localparam logic [CODE_W-1:0] REPEAT_CODE       = 32'hFFFF_FFFF;

  typedef enum logic [IDX_W-1:0] {
    REG_CW_CODE           = 4'd0,
    REG_CCW_CODE          = 4'd1,
    REG_STOP_DELAY_MS     = 4'd2,
    REG_ONE_THRESHOLD_US  = 4'd3,
    REG_LEADER_LOW_MIN_US = 4'd4,
    REG_LEADER_LOW_MAX_US = 4'd5,
    REG_BIT_LOW_MIN_US    = 4'd6,
    REG_BIT_LOW_MAX_US    = 4'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [CODE_W-1:0] cw_code;
    logic [CODE_W-1:0] ccw_code;
    logic [DLY_W-1:0]  stop_delay_ms;
    logic [US_W-1:0]   one_threshold_us;
    logic [US_W-1:0]   leader_low_min_us;
    logic [US_W-1:0]   leader_low_max_us;
    logic [US_W-1:0]   bit_low_min_us;
    logic [US_W-1:0]   bit_low_max_us;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    cw_code:           32'h00FF_629D,
    ccw_code:          32'h00FF_A857,
    stop_delay_ms:     16'd3000,
    one_threshold_us:  15'd1000,
    leader_low_min_us: 15'd8000,
    leader_low_max_us: 15'd10000,
    bit_low_min_us:    15'd400,
    bit_low_max_us:    15'd700
  };

  typedef struct packed {
    logic              code_valid;
    logic [CODE_W-1:0] code;
  } frame_res_t;

  typedef struct packed {
    logic step_valid;
    logic step_dir;
    logic running;
  } motor_res_t;

  function automatic logic in_window(logic [US_W-1:0] w, logic [US_W-1:0] lo,
                                     logic [US_W-1:0] hi);
    return (w >= lo) && (w <= hi);
  endfunction

endpackage

// File: sv/nec_ir_stepper_remote_core.sv
// Top level: input register, frame decoder, motor control and result register.
// An accepted input transaction is held in the input register, then its result in the result register.
// Throughput: one transaction per cycle, set by the single-pass decode between the
// input register and the result register; stalls only while the result register is held.
// Reset (rst, synchronous): decoder idle, motor stopped and clockwise, stamp zero,
// registers at their defaults, both pipeline stages empty.
module nec_ir_stepper_remote_core import nir_pkg::*; #(
  parameter int unsigned CODE_BITS = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              kind,
  input  logic              pulse_level,
  input  logic [US_W-1:0]   pulse_us,
  input  logic [MS_W-1:0]   now_ms,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              code_valid,
  output logic [CODE_W-1:0] code,
  output logic              step_valid,
  output logic              step_dir,
  output logic              running,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [31:0]       cfg_data
);

  cfg_t            cfg;
  logic            s1_valid;
  logic            s1_kind;
  logic            s1_level;
  logic [US_W-1:0] s1_us;
  logic [MS_W-1:0] s1_now;
  logic            advance;
  logic            proc;
  frame_res_t      frame_res;
  motor_res_t      motor_res;

  assign cfg_ready = 1'b1;
  assign advance   = !out_valid || !out_stall;
  assign proc      = s1_valid && advance;
  assign in_stall  = s1_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_CW_CODE:           cfg.cw_code           <= cfg_data;
        REG_CCW_CODE:          cfg.ccw_code          <= cfg_data;
        REG_STOP_DELAY_MS:     cfg.stop_delay_ms     <= cfg_data[DLY_W-1:0];
        REG_ONE_THRESHOLD_US:  cfg.one_threshold_us  <= cfg_data[US_W-1:0];
        REG_LEADER_LOW_MIN_US: cfg.leader_low_min_us <= cfg_data[US_W-1:0];
        REG_LEADER_LOW_MAX_US: cfg.leader_low_max_us <= cfg_data[US_W-1:0];
        REG_BIT_LOW_MIN_US:    cfg.bit_low_min_us    <= cfg_data[US_W-1:0];
        REG_BIT_LOW_MAX_US:    cfg.bit_low_max_us    <= cfg_data[US_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_kind  <= kind;
      s1_level <= pulse_level;
      s1_us    <= pulse_us;
      s1_now   <= now_ms;
    end
  end

  nir_frame #(
    .CODE_BITS(CODE_BITS)
  ) u_frame (
    .clk     (clk),
    .rst     (rst),
    .en      (proc && !s1_kind),
    .level   (s1_level),
    .width_us(s1_us),
    .cfg     (cfg),
    .res     (frame_res)
  );

  nir_motor u_motor (
    .clk   (clk),
    .rst   (rst),
    .tick  (proc && s1_kind),
    .frame (frame_res),
    .now_ms(s1_now),
    .cfg   (cfg),
    .res   (motor_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      code_valid <= frame_res.code_valid;
      code       <= frame_res.code;
      step_valid <= motor_res.step_valid;
      step_dir   <= motor_res.step_dir;
      running    <= motor_res.running;
    end
  end

endmodule

// File: sv/nir_frame.sv
// NEC frame decoder: leader windows, bit marks and spaces, MSB-first code assembly.
module nir_frame import nir_pkg::*; #(
  parameter int unsigned CODE_BITS = 32
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            level,
  input  logic [US_W-1:0] width_us,
  input  cfg_t            cfg,
  output frame_res_t      res
);

  localparam int unsigned CNT_W = $clog2(CODE_BITS);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_LEAD_SPACE,
    PH_BIT_MARK,
    PH_BIT_SPACE
  } phase_t;

  phase_t            phase, phase_next;
  logic [CNT_W-1:0]  bit_count, bit_count_next;
  logic [CODE_W-1:0] shift_code, shift_code_next;
  logic [CODE_W-1:0] shifted;

  assign shifted = {shift_code[CODE_W-2:0], (width_us > cfg.one_threshold_us)};

  always_comb begin
    phase_next      = phase;
    bit_count_next  = bit_count;
    shift_code_next = shift_code;
    res             = '0;
    if (en) begin
      unique case (phase)
        PH_IDLE: begin
          if (!level && in_window(width_us, cfg.leader_low_min_us, cfg.leader_low_max_us)) begin
            phase_next = PH_LEAD_SPACE;
          end
        end
        PH_LEAD_SPACE: begin
          if (level && in_window(width_us, LEAD_SPACE_MIN_US, LEAD_SPACE_MAX_US)) begin
            phase_next      = PH_BIT_MARK;
            bit_count_next  = '0;
            shift_code_next = '0;
          end else begin
            phase_next = PH_IDLE;
          end
        end
        PH_BIT_MARK: begin
          if (!level && in_window(width_us, cfg.bit_low_min_us, cfg.bit_low_max_us)) begin
            phase_next = PH_BIT_SPACE;
          end else begin
            phase_next = PH_IDLE;
          end
        end
        PH_BIT_SPACE: begin
          if (level && (width_us != '0)) begin
            shift_code_next = shifted;
            if (bit_count == CNT_W'(CODE_BITS - 1)) begin
              res.code_valid = 1'b1;
              res.code       = shifted;
              phase_next     = PH_IDLE;
              bit_count_next = '0;
            end else begin
              bit_count_next = bit_count + 1'b1;
              phase_next     = PH_BIT_MARK;
            end
          end else begin
            phase_next = PH_IDLE;
          end
        end
        default: phase_next = PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      bit_count  <= '0;
      shift_code <= '0;
    end else begin
      phase      <= phase_next;
      bit_count  <= bit_count_next;
      shift_code <= shift_code_next;
    end
  end

endmodule

// File: sv/nir_motor.sv
// Run flag, direction and command time stamp, with step requests on service ticks.
module nir_motor import nir_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            tick,
  input  frame_res_t      frame,
  input  logic [MS_W-1:0] now_ms,
  input  cfg_t            cfg,
  output motor_res_t      res
);

  logic            run, run_next;
  logic            dir_ccw, dir_ccw_next;
  logic [MS_W-1:0] last_ms, last_ms_next;
  logic [MS_W-1:0] elapsed;

  assign elapsed = now_ms - last_ms;

  always_comb begin
    run_next     = run;
    dir_ccw_next = dir_ccw;
    last_ms_next = last_ms;
    res          = '0;
    if (tick && run) begin
      if (elapsed > MS_W'(cfg.stop_delay_ms)) begin
        run_next = 1'b0;
      end else begin
        res.step_valid = 1'b1;
        res.step_dir   = dir_ccw;
      end
    end
    if (frame.code_valid) begin
      if (frame.code == cfg.cw_code) begin
        dir_ccw_next = 1'b0;
        run_next     = 1'b1;
        last_ms_next = now_ms;
      end else if (frame.code == cfg.ccw_code) begin
        dir_ccw_next = 1'b1;
        run_next     = 1'b1;
        last_ms_next = now_ms;
      end else if (frame.code == REPEAT_CODE) begin
        if (run) begin
          last_ms_next = now_ms;
        end
      end
    end
    res.running = run_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run     <= 1'b0;
      dir_ccw <= 1'b0;
      last_ms <= '0;
    end else begin
      run     <= run_next;
      dir_ccw <= dir_ccw_next;
      last_ms <= last_ms_next;
    end
  end

endmodule

// File: sv/nir_checker.sv
// Port-level checker for the NEC IR stepper remote core and its bind statement.
module nir_checker import nir_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_stall,
  input logic              code_valid,
  input logic [CODE_W-1:0] code,
  input logic              step_valid,
  input logic              step_dir,
  input logic              running
);

  a_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(code) && $stable(running))
    else $error("Stalled result transaction changed.");

  a_step_running: assert property (@(posedge clk) disable iff (rst)
    out_valid && step_valid |-> running)
    else $error("Step requested while the motor is stopped.");

  a_code_no_step: assert property (@(posedge clk) disable iff (rst)
    out_valid && code_valid |-> !step_valid)
    else $error("Code and step reported by one transaction.");

  a_code_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !code_valid |-> (code == '0))
    else $error("Code is nonzero without a completed frame.");

  a_dir_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !step_valid |-> !step_dir)
    else $error("Step direction is set without a step.");

endmodule

bind nec_ir_stepper_remote_core nir_checker u_nir_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .code_valid(code_valid),
  .code      (code),
  .step_valid(step_valid),
  .step_dir  (step_dir),
  .running   (running)
);
